// ===== sv/i2cms_pkg.sv =====
`timescale 1ns / 1ps

package i2cms_pkg;

    // Command codes carried in the func field of an input transfer
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

    // Register values after reset
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd50;

    // Sequence currently being run
    typedef enum logic [5:0] {
        OP_IDLE     = 6'b000001,
        OP_START    = 6'b000010,
        OP_STOP     = 6'b000100,
        OP_WRITE    = 6'b001000,
        OP_READ     = 6'b010000,
        OP_FAILSTOP = 6'b100000
    } op_kind_t;

    // One input transfer
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_sample;
    } in_item_t;

    // One result transfer
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_failed;
        logic [7:0] read_byte;
        logic       rejected;
    } out_item_t;

endpackage

// ===== sv/i2cms_core.sv =====
`timescale 1ns / 1ps

module i2cms_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  i2cms_pkg::in_item_t                   item,
    output i2cms_pkg::out_item_t                  result,
    input  logic                                  cfg_write,
    input  logic [i2cms_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [i2cms_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [15:0]          half_period_reg;
    logic [7:0]           ack_timeout_reg;

    i2cms_pkg::op_kind_t  op_reg, op_next;
    logic [3:0]           step_reg, step_next;
    logic [3:0]           bit_count_reg, bit_count_next;
    logic [15:0]          wait_reg, wait_next;
    logic [7:0]           poll_reg, poll_next;
    logic [7:0]           shift_reg, shift_next;
    logic                 ack_choice_reg, ack_choice_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic [7:0]           last_read_reg, last_read_next;

    logic [15:0]          hold_val;
    logic                 fin;
    logic                 fail;
    logic                 rej;
    logic                 do_expire;
    logic                 do_poll;

    // A zero half period still holds each level for one tick.
    assign hold_val = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= i2cms_pkg::HALF_PERIOD_RESET;
            ack_timeout_reg <= i2cms_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == i2cms_pkg::CFG_HALF_PERIOD)
            begin
                half_period_reg <= cfg_data;
            end
            else if (cfg_index == i2cms_pkg::CFG_ACK_TIMEOUT)
            begin
                ack_timeout_reg <= cfg_data[7:0];
            end
        end
    end

    // Next sequencer state for the item being transferred.
    always_comb
    begin
        op_next         = op_reg;
        step_next       = step_reg;
        bit_count_next  = bit_count_reg;
        wait_next       = wait_reg;
        poll_next       = poll_reg;
        shift_next      = shift_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        last_read_next  = last_read_reg;
        fin             = 1'b0;
        fail            = 1'b0;
        rej             = 1'b0;
        do_expire       = 1'b0;
        do_poll         = 1'b0;

        // Decide what a tick does: count down the hold, poll, or advance.
        if (item.func == i2cms_pkg::FUNC_TICK)
        begin
            if (op_reg != i2cms_pkg::OP_IDLE)
            begin
                if (wait_reg != 16'd0)
                begin
                    wait_next = wait_reg - 16'd1;
                    do_expire = (wait_reg == 16'd1);
                end
                else if (op_reg == i2cms_pkg::OP_WRITE && step_reg == 4'd5)
                begin
                    do_poll = 1'b1;
                end
                else
                begin
                    do_expire = 1'b1;
                end
            end
        end
        else if (item.func <= i2cms_pkg::FUNC_READ)
        begin
            if (op_reg != i2cms_pkg::OP_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                bit_count_next = 4'd0;
                poll_next      = 8'd0;
                wait_next      = hold_val;
                step_next      = 4'd0;
                unique case (item.func)
                    i2cms_pkg::FUNC_START:
                    begin
                        op_next  = i2cms_pkg::OP_START;
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    i2cms_pkg::FUNC_STOP:
                    begin
                        op_next  = i2cms_pkg::OP_STOP;
                        sda_next = 1'b0;
                    end
                    i2cms_pkg::FUNC_WRITE:
                    begin
                        op_next    = i2cms_pkg::OP_WRITE;
                        sda_next   = item.data_byte[7];
                        shift_next = {item.data_byte[6:0], 1'b0};
                    end
                    default:
                    begin
                        op_next         = i2cms_pkg::OP_READ;
                        ack_choice_next = item.send_ack;
                        shift_next      = 8'd0;
                        sda_next        = 1'b1;
                        scl_next        = 1'b1;
                    end
                endcase
            end
        end

        // End of a hold: perform the next step of the running sequence.
        if (do_expire)
        begin
            unique case (op_reg)
                i2cms_pkg::OP_START:
                begin
                    if (step_reg == 4'd0)
                    begin
                        sda_next  = 1'b0;
                        wait_next = hold_val;
                        step_next = 4'd1;
                    end
                    else if (step_reg == 4'd1)
                    begin
                        scl_next  = 1'b0;
                        wait_next = hold_val;
                        step_next = 4'd2;
                    end
                    else
                    begin
                        op_next   = i2cms_pkg::OP_IDLE;
                        step_next = 4'd0;
                        wait_next = 16'd0;
                        fin       = 1'b1;
                    end
                end
                i2cms_pkg::OP_STOP,
                i2cms_pkg::OP_FAILSTOP:
                begin
                    if (step_reg == 4'd0)
                    begin
                        scl_next  = 1'b1;
                        wait_next = hold_val;
                        step_next = 4'd1;
                    end
                    else if (step_reg == 4'd1)
                    begin
                        sda_next  = 1'b1;
                        wait_next = hold_val;
                        step_next = 4'd2;
                    end
                    else
                    begin
                        op_next   = i2cms_pkg::OP_IDLE;
                        step_next = 4'd0;
                        wait_next = 16'd0;
                        fin       = 1'b1;
                        fail      = (op_reg == i2cms_pkg::OP_FAILSTOP);
                    end
                end
                i2cms_pkg::OP_WRITE:
                begin
                    if (step_reg == 4'd0)
                    begin
                        scl_next  = 1'b1;
                        wait_next = hold_val;
                        step_next = 4'd1;
                    end
                    else if (step_reg == 4'd1)
                    begin
                        scl_next  = 1'b0;
                        wait_next = hold_val;
                        step_next = 4'd2;
                    end
                    else if (step_reg == 4'd2)
                    begin
                        bit_count_next = bit_count_reg + 4'd1;
                        wait_next      = hold_val;
                        if (bit_count_next < 4'd8)
                        begin
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            step_next  = 4'd0;
                        end
                        else
                        begin
                            sda_next  = 1'b1;
                            step_next = 4'd3;
                        end
                    end
                    else if (step_reg == 4'd3)
                    begin
                        scl_next  = 1'b1;
                        wait_next = hold_val;
                        step_next = 4'd4;
                    end
                    else if (step_reg == 4'd4)
                    begin
                        // The first ACK sample is taken on this same tick.
                        step_next = 4'd5;
                        wait_next = 16'd0;
                        poll_next = 8'd0;
                        do_poll   = 1'b1;
                    end
                    else
                    begin
                        op_next   = i2cms_pkg::OP_IDLE;
                        step_next = 4'd0;
                        wait_next = 16'd0;
                        fin       = 1'b1;
                    end
                end
                i2cms_pkg::OP_READ:
                begin
                    unique case (step_reg)
                        4'd0:
                        begin
                            shift_next = {shift_reg[6:0], item.sda_sample};
                            scl_next   = 1'b0;
                            wait_next  = hold_val;
                            step_next  = 4'd1;
                        end
                        4'd1:
                        begin
                            bit_count_next = bit_count_reg + 4'd1;
                            wait_next      = hold_val;
                            if (bit_count_next < 4'd8)
                            begin
                                scl_next  = 1'b1;
                                step_next = 4'd0;
                            end
                            else
                            begin
                                last_read_next = shift_reg;
                                if (ack_choice_reg)
                                begin
                                    scl_next  = 1'b0;
                                    step_next = 4'd2;
                                end
                                else
                                begin
                                    sda_next  = 1'b1;
                                    step_next = 4'd7;
                                end
                            end
                        end
                        4'd2:
                        begin
                            sda_next  = 1'b0;
                            wait_next = hold_val;
                            step_next = 4'd3;
                        end
                        4'd3:
                        begin
                            scl_next  = 1'b1;
                            wait_next = hold_val;
                            step_next = 4'd4;
                        end
                        4'd4:
                        begin
                            scl_next  = 1'b0;
                            wait_next = hold_val;
                            step_next = 4'd5;
                        end
                        4'd5:
                        begin
                            sda_next  = 1'b1;
                            wait_next = hold_val;
                            step_next = 4'd6;
                        end
                        4'd7:
                        begin
                            scl_next  = 1'b1;
                            wait_next = hold_val;
                            step_next = 4'd8;
                        end
                        4'd8:
                        begin
                            scl_next  = 1'b0;
                            wait_next = hold_val;
                            step_next = 4'd9;
                        end
                        default:
                        begin
                            op_next   = i2cms_pkg::OP_IDLE;
                            step_next = 4'd0;
                            wait_next = 16'd0;
                            fin       = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    op_next   = i2cms_pkg::OP_IDLE;
                    step_next = 4'd0;
                    wait_next = 16'd0;
                    fin       = 1'b1;
                end
            endcase
        end

        // ACK poll: a low sample ends it, too many high samples fail.
        if (do_poll)
        begin
            if (!item.sda_sample)
            begin
                scl_next  = 1'b0;
                wait_next = hold_val;
                step_next = 4'd6;
            end
            else if (poll_next >= ack_timeout_reg)
            begin
                op_next   = i2cms_pkg::OP_FAILSTOP;
                sda_next  = 1'b0;
                wait_next = hold_val;
                step_next = 4'd0;
            end
            else
            begin
                poll_next = poll_next + 8'd1;
            end
        end
    end

    // Result fields follow from the new state.
    always_comb
    begin
        result.scl_out    = scl_next;
        result.sda_out    = sda_next;
        result.busy_res   = (op_next != i2cms_pkg::OP_IDLE);
        result.done_res   = fin;
        result.ack_failed = fail;
        result.read_byte  = last_read_next;
        result.rejected   = rej;
    end

    // Sequencer state, updated once per input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= i2cms_pkg::OP_IDLE;
            step_reg       <= 4'd0;
            bit_count_reg  <= 4'd0;
            wait_reg       <= 16'd0;
            poll_reg       <= 8'd0;
            shift_reg      <= 8'd0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            last_read_reg  <= 8'd0;
        end
        else if (accept)
        begin
            op_reg         <= op_next;
            step_reg       <= step_next;
            bit_count_reg  <= bit_count_next;
            wait_reg       <= wait_next;
            poll_reg       <= poll_next;
            shift_reg      <= shift_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            last_read_reg  <= last_read_next;
        end
    end

endmodule

// ===== sv/i2c_master_bit_sequencer.sv =====
`timescale 1ns / 1ps
// Results are registered in an output buffer whose head is presented on out_item.
// One item per cycle while in_ready is high; each updates the sequencer in one pass.
// A two-entry output buffer lets one more item be taken while a result waits to be taken.
// Reset: asynchronous, active low; the bus lines are released, the sequencer is idle and
// the half period and ACK timeout registers return to 5 and 50.

module i2c_master_bit_sequencer
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  i2cms_pkg::in_item_t                   in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output i2cms_pkg::out_item_t                  out_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [i2cms_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [i2cms_pkg::CFG_DATA_W-1:0]      cfg_data
);

    i2cms_pkg::out_item_t  result;
    i2cms_pkg::out_item_t  head_reg;
    i2cms_pkg::out_item_t  skid_reg;
    logic                  head_valid_reg;
    logic                  skid_valid_reg;
    logic                  push;
    logic                  pop;

    // Handshake
    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = head_valid_reg && out_ready;
    assign out_valid = head_valid_reg;
    assign out_item  = head_reg;

    i2cms_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (push),
        .item      (in_item),
        .result    (result),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Output buffer control: head holds the oldest result, skid the next one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (head_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            head_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            head_valid_reg <= 1'b0;
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (head_valid_reg && !pop)
            begin
                skid_reg <= result;
            end
            else
            begin
                head_reg <= result;
            end
        end
    end

endmodule
